// ----- design/aesm_pkg.sv -----
// AES mode engine package: field widths, register and operation codes,
// S-box tables and GF(2^8) helpers. No dependencies.
`default_nettype none
package aesm_pkg;
    localparam int BLOCK_W  = 64;
    localparam int CNT_W    = 5;
    localparam int CFG_IDX_W = 3;
    localparam int RK_DEPTH = 30;

    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_KEY1 = 3'd1;
    localparam logic [2:0] REG_KEY2 = 3'd2;
    localparam logic [2:0] REG_KEY3 = 3'd3;
    localparam logic [2:0] REG_IVH  = 3'd4;
    localparam logic [2:0] REG_IVL  = 3'd5;
    localparam logic [2:0] REG_KSZ  = 3'd6;
    localparam logic [2:0] REG_OP   = 3'd7;

    localparam logic [2:0] OP_ECB_ENC = 3'd0;
    localparam logic [2:0] OP_ECB_DEC = 3'd1;
    localparam logic [2:0] OP_CBC_ENC = 3'd2;
    localparam logic [2:0] OP_CBC_DEC = 3'd3;
    localparam logic [2:0] OP_CTR     = 3'd4;

    localparam logic [1:0] KSZ_128 = 2'd0;
    localparam logic [1:0] KSZ_192 = 2'd1;

    typedef logic [7:0] byte_t;
    typedef logic [127:0] blk_t;

    localparam logic [2047:0] SBOX_TBL = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};
    localparam logic [2047:0] ISBOX_TBL = {
        128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

    function automatic byte_t sbox(input byte_t x);
        return SBOX_TBL[2047 - 8 * int'(x) -: 8];
    endfunction
    function automatic byte_t isbox(input byte_t x);
        return ISBOX_TBL[2047 - 8 * int'(x) -: 8];
    endfunction
    function automatic byte_t xt(input byte_t x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction
    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] c);
        byte_t a0, a1, a2, a3;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3, a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3, xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
    endfunction

    // inverse column: premultiply by {04,05} then forward mix
    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        byte_t a0, a1, a2, a3, u, v;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        u = xt(xt(a0 ^ a2));
        v = xt(xt(a1 ^ a3));
        return mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
    endfunction

    function automatic blk_t mix_blk(input blk_t s, input logic inv);
        blk_t r;
        for (int c = 0; c < 4; c++)
            r[127 - 32 * c -: 32] = inv ? inv_mix_col(s[127 - 32 * c -: 32])
                                        : mix_col(s[127 - 32 * c -: 32]);
        return r;
    endfunction

    function automatic blk_t sub_shift(input blk_t s, input logic inv);
        blk_t t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                if (!inv)
                    t[127 - 8 * (r + 4 * c) -: 8] =
                        sbox(s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]);
                else
                    t[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] =
                        isbox(s[127 - 8 * (r + 4 * c) -: 8]);
            end
        return t;
    endfunction
endpackage
`default_nettype wire

// ----- design/aesm_if.sv -----
// Valid/ready stream interfaces for the AES mode engine.
// Depends on aesm_pkg.
`default_nettype none
interface aesm_in_if;
    import aesm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [BLOCK_W-1:0]   block_high;
    logic [BLOCK_W-1:0]   block_low;
    logic [CNT_W-1:0]     byte_count;
    logic                 restart;
    modport source (output valid, block_high, block_low, byte_count, restart, input ready);
    modport sink   (input valid, block_high, block_low, byte_count, restart, output ready);
endinterface

interface aesm_out_if;
    import aesm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [BLOCK_W-1:0]   result_high;
    logic [BLOCK_W-1:0]   result_low;
    modport source (output valid, result_high, result_low, input ready);
    modport sink   (input valid, result_high, result_low, output ready);
endinterface
`default_nettype wire

// ----- design/aesm_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module aesm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 30
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ----- design/aes_block_cipher_modes.sv -----
// AES-128/192/256 in ECB, CBC and CTR mode, round keys held in RAM.
// For each of the rounds + 1 round keys, a block reads two 64-bit round-key
// halves from the single-port key RAMs in turn (ST_RUN), then applies the round
// in ST_DONE. After a key or key-size change, key expansion (ST_EXP) and the
// derivation of the decryption keys (ST_INV) run before the first block.
// One block in flight at a time. The result is held in an output register;
// the next block is taken while it waits and stalls in its last round until
// the held result is taken. Reset (rst_n, async low) clears the control and
// configuration registers and the chain.
// Depends on aesm_pkg, aesm_if, aesm_ram.
`default_nettype none
module aes_block_cipher_modes (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [aesm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [aesm_pkg::BLOCK_W-1:0]     cfg_data,
    aesm_in_if.sink                               in_ch,
    aesm_out_if.source                            out_ch
);
    import aesm_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXP  = 3'd1;  // encryption key expansion
    localparam logic [2:0] ST_INV  = 3'd2;  // derive decryption keys
    localparam logic [2:0] ST_RUN  = 3'd3;  // cipher rounds
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam int AW = $clog2(RK_DEPTH);

    // configuration
    logic [63:0] key_reg [4];
    logic [63:0] ivh_reg, ivl_reg;
    logic [1:0]  ksz_reg;
    logic [2:0]  op_reg;
    logic        kval_reg;

    // engine state
    logic [2:0]   st_reg;
    logic [255:0] win_reg;        // last nk key words, newest at the low end
    logic [5:0]   wi_reg;         // next key word index
    logic [3:0]   wmod_reg;       // key word index modulo nk
    logic [7:0]   rc_reg;
    logic [63:0]  wacc_reg;       // first word pair being formed
    logic [4:0]   ci_reg;         // RAM sweep counter
    logic         ph_reg;         // sub-step phase
    logic [127:0] st_blk_reg;
    logic [63:0]  khi_reg;
    logic [3:0]   rnd_reg;
    logic [127:0] chain_reg;
    logic [127:0] inb_reg;
    logic [4:0]   cnt_reg;
    logic         dec_reg;
    logic         ovalid_reg;
    logic [127:0] res_reg;

    // RAM ports
    logic          e_we, d_we;
    logic [AW-1:0] e_addr, d_addr;
    logic [63:0]   e_wd, d_wd, e_rd, d_rd;

    aesm_ram #(.WIDTH(64), .DEPTH(RK_DEPTH)) u_enc_keys
        (.clk(clk), .we(e_we), .addr(e_addr), .wdata(e_wd), .rdata(e_rd));
    aesm_ram #(.WIDTH(64), .DEPTH(RK_DEPTH)) u_dec_keys
        (.clk(clk), .we(d_we), .addr(d_addr), .wdata(d_wd), .rdata(d_rd));

    logic [3:0] nk, nr;
    always_comb
    begin
        unique case (ksz_reg)
            KSZ_128: begin nk = 4'd4; nr = 4'd10; end
            KSZ_192: begin nk = 4'd6; nr = 4'd12; end
            default: begin nk = 4'd8; nr = 4'd14; end
        endcase
    end

    // next expanded key word
    logic [31:0] w_prev, w_back, w_t, w_new;
    logic [3:0]  wmod;
    always_comb
    begin
        w_prev = win_reg[31:0];
        w_back = win_reg[32 * nk - 1 -: 32];
        wmod   = wmod_reg;
        if (wmod == 4'd0)
            w_t = sub_word({w_prev[23:0], w_prev[31:24]}) ^ {rc_reg, 24'd0};
        else if (nk == 4'd8 && wmod == 4'd4)
            w_t = sub_word(w_prev);
        else
            w_t = w_prev;
        w_new = w_back ^ w_t;
    end

    logic [5:0]  total_w;
    logic [63:0] kpair;
    assign total_w = 6'({nr + 4'd1, 2'b00});
    // during the initial key words, the words come straight from the key
    assign kpair = key_reg[wi_reg[2:1]];

    logic in_xfer, out_xfer;
    assign in_ch.ready  = (st_reg == ST_IDLE);
    assign in_xfer      = in_ch.valid && in_ch.ready;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.result_high = res_reg[127:64];
    assign out_ch.result_low  = res_reg[63:0];
    assign out_xfer     = out_ch.valid && out_ch.ready;

    // last round completes once the output register is free
    logic fin, kdone;
    assign fin   = (st_reg == ST_DONE) && (rnd_reg == nr) && (!ovalid_reg || out_xfer);
    assign kdone = (st_reg == ST_INV) && ph_reg && (ci_reg == 5'({nr, 1'b1}));

    // per-round datapath; ph 0 reads key high, ph 1 has high, gets low
    logic [127:0] rkey, rnd_out;
    logic         dec_sel;
    assign dec_sel = dec_reg;
    assign rkey = {khi_reg, dec_sel ? d_rd : e_rd};
    always_comb
    begin
        blk_t t;
        t = sub_shift(st_blk_reg, dec_sel);
        if (rnd_reg != nr)
            t = mix_blk(t, dec_sel);
        rnd_out = (rnd_reg == 4'd0) ? (st_blk_reg ^ rkey) : (t ^ rkey);
    end

    // CTR result with byte mask
    logic [127:0] ctr_mask;
    logic [4:0]   ncl;
    always_comb
    begin
        ncl = (cnt_reg > 5'd16) ? 5'd16 : cnt_reg;
        for (int b = 0; b < 16; b++)
            ctr_mask[127 - 8 * b -: 8] = (5'(b) < ncl) ? 8'hff : 8'h00;
    end

    logic dec_op;
    assign dec_op = (op_reg == OP_ECB_DEC) || (op_reg == OP_CBC_DEC);

    // RAM address / write control
    always_comb
    begin
        e_we = 1'b0; d_we = 1'b0;
        e_addr = '0; d_addr = '0;
        e_wd = {wacc_reg[31:0], w_new};
        d_wd = '0;
        unique case (st_reg)
            ST_EXP:
            begin
                e_addr = AW'(wi_reg[5:1]);
                if (wi_reg < 6'(nk))
                    e_wd = kpair;
                e_we = wi_reg[0];
            end
            ST_INV:
            begin
                // phase 0 reads pair, phase 1 writes its transform
                e_addr = AW'(ci_reg);
                d_addr = AW'({nr, 1'b0} - {ci_reg[4:1], 1'b0} + {3'd0, ci_reg[0]});
                d_we   = ph_reg;
            end
            ST_RUN:
            begin
                e_addr = AW'({rnd_reg, ph_reg});
                d_addr = e_addr;
            end
            ST_DONE:
            begin
                // keep the low half on the read port while the round waits
                e_addr = AW'({rnd_reg, 1'b1});
                d_addr = e_addr;
            end
            default: ;
        endcase
        if (st_reg == ST_INV)
        begin
            // inner round keys get InvMixColumns, a half at a time
            if (ci_reg[4:1] == 4'd0 || ci_reg[4:1] == nr)
                d_wd = e_rd;
            else
                d_wd = {inv_mix_col(e_rd[63:32]), inv_mix_col(e_rd[31:0])};
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
            ivh_reg <= '0; ivl_reg <= '0; ksz_reg <= KSZ_128; op_reg <= OP_ECB_ENC;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index) inside
                REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_reg[cfg_index[1:0]] <= cfg_data;
                REG_IVH: ivh_reg <= cfg_data;
                REG_IVL: ivl_reg <= cfg_data;
                REG_KSZ: ksz_reg <= cfg_data[1:0];
                REG_OP:  op_reg  <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE; kval_reg <= 1'b0; ovalid_reg <= 1'b0;
            chain_reg <= '0; wi_reg <= '0; wmod_reg <= '0; ci_reg <= '0; ph_reg <= 1'b0;
            rnd_reg <= '0; rc_reg <= 8'h01; dec_reg <= 1'b0;
        end
        else
        begin
            if (fin)
                ovalid_reg <= 1'b1;
            else if (out_xfer)
                ovalid_reg <= 1'b0;
            if (cfg_we && (cfg_index == REG_KEY0 || cfg_index == REG_KEY1 ||
                           cfg_index == REG_KEY2 || cfg_index == REG_KEY3 ||
                           cfg_index == REG_KSZ))
                kval_reg <= 1'b0;
            else if (kdone)
                kval_reg <= 1'b1;
            unique case (st_reg)
                ST_IDLE:
                    if (in_xfer)
                    begin
                        inb_reg <= {in_ch.block_high, in_ch.block_low};
                        cnt_reg <= in_ch.byte_count;
                        if (in_ch.restart)
                            chain_reg <= {ivh_reg, ivl_reg};
                        wi_reg <= '0; wmod_reg <= '0; rc_reg <= 8'h01;
                        st_reg <= kval_reg ? ST_RUN : ST_EXP;
                        ph_reg <= 1'b0; rnd_reg <= '0;
                        dec_reg <= dec_op;
                    end
                ST_EXP:
                begin
                    logic [31:0] w;
                    w = (wi_reg < 6'(nk)) ? (wi_reg[0] ? kpair[31:0] : kpair[63:32])
                                           : w_new;
                    win_reg  <= {win_reg[223:0], w};
                    wacc_reg <= {wacc_reg[31:0], w};
                    if (wi_reg >= 6'(nk) && wmod == 4'd0)
                        rc_reg <= xt(rc_reg);
                    wi_reg <= wi_reg + 6'd1;
                    wmod_reg <= (wmod_reg == nk - 4'd1) ? 4'd0 : wmod_reg + 4'd1;
                    if (wi_reg + 6'd1 == total_w)
                    begin
                        st_reg <= ST_INV; ci_reg <= '0; ph_reg <= 1'b0;
                    end
                end
                ST_INV:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        ci_reg <= ci_reg + 5'd1;
                        if (kdone)
                        begin
                            st_reg <= ST_RUN; rnd_reg <= '0;
                        end
                    end
                end
                ST_RUN:
                begin
                    // ph 0: address high half; ph 1: latch high, address low;
                    // then ST_DONE consumes both (via khi_reg + rdata)
                    ph_reg <= !ph_reg;
                    if (!ph_reg && rnd_reg == 4'd0)
                    begin
                        unique case (op_reg)
                            OP_CBC_ENC: st_blk_reg <= inb_reg ^ chain_reg;
                            OP_CTR:     st_blk_reg <= chain_reg;
                            default:    st_blk_reg <= inb_reg;
                        endcase
                    end
                    if (ph_reg)
                        st_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    // round cycle: high half came in last cycle, low half now
                    if (rnd_reg == nr)
                    begin
                        if (fin)
                        begin
                            st_reg <= ST_IDLE;
                            unique case (op_reg) inside
                                OP_ECB_ENC, OP_ECB_DEC: res_reg <= rnd_out;
                                OP_CBC_ENC:
                                begin
                                    res_reg <= rnd_out; chain_reg <= rnd_out;
                                end
                                OP_CBC_DEC:
                                begin
                                    res_reg <= rnd_out ^ chain_reg; chain_reg <= inb_reg;
                                end
                                OP_CTR:
                                    if (ncl == 5'd0)
                                        res_reg <= '0;
                                    else
                                    begin
                                        res_reg <= (inb_reg ^ rnd_out) & ctr_mask;
                                        chain_reg <= chain_reg + 128'd1;
                                    end
                                default: res_reg <= '0;
                            endcase
                        end
                    end
                    else
                    begin
                        st_blk_reg <= rnd_out;
                        rnd_reg <= rnd_reg + 4'd1;
                        ph_reg <= 1'b0;
                        st_reg <= ST_RUN;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    // high round-key half, addressed in ph 0, is captured from the read port in ph 1
    always_ff @(posedge clk)
    begin
        if (st_reg == ST_RUN && ph_reg)
            khi_reg <= dec_reg ? d_rd : e_rd;
    end

    // at most one block in flight
    assert property (@(posedge clk) disable iff (!rst_n) in_xfer |=> !in_ch.ready)
        else $error("input taken while busy");
    // a held result stays put until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(res_reg))
        else $error("result lost");
    // the cipher never runs on stale keys
    assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_DONE |-> kval_reg)
        else $error("rounds without valid keys");
endmodule
`default_nettype wire

// ----- tb/tb_aes_block_cipher_modes.sv -----
// Self-checking testbench for aes_block_cipher_modes: directed and random blocks in every
// mode and key size, checked against an AES predictor held in the bench.
// Depends on aesm_pkg, aesm_if and the design files.
`timescale 1ns / 1ps
module tb_aes_block_cipher_modes;
    import aesm_pkg::*;

    typedef struct packed {
        logic [BLOCK_W-1:0] hi;
        logic [BLOCK_W-1:0] lo;
        logic [CNT_W-1:0]   cnt;
        logic               rst;
    } blk_item_t;

    localparam logic [2:0] OP_RSVD_LO = 3'd5;
    localparam logic [2:0] OP_RSVD_HI = 3'd7;
    localparam logic [1:0] KSZ_256 = 2'd2;
    localparam logic [1:0] KSZ_ALT = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BLOCK_W-1:0] cfg_data = '0;

    aesm_in_if  in_vif ();
    aesm_out_if out_vif ();

    aes_block_cipher_modes DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_vif),
        .out_ch    (out_vif)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor state
    logic [7:0]   fwd_sb [256];
    logic [7:0]   inv_sb [256];
    logic [63:0]  m_key [4];
    logic [63:0]  m_ivh, m_ivl;
    logic [1:0]   m_ksz;
    logic [2:0]   m_op;
    logic [127:0] enc_rk [15];
    logic [127:0] dec_rk [15];
    logic [127:0] m_chain;
    logic         m_keys_ok;
    int           m_rounds;

    blk_item_t    pending_blocks [$];
    logic [127:0] expected_results [$];
    int           errors = 0;
    int           results_seen = 0;
    int           blocks_sent = 0;
    logic         no_idle = 1'b0;
    logic         hold_req = 1'b0;
    logic         hold_taken = 1'b0;
    int           hold_cnt = 0;

    function automatic logic [7:0] gf_x2(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i]) r = r ^ a;
            a = gf_x2(a);
        end
        return r;
    endfunction

    function automatic logic [7:0] rol8(input logic [7:0] x, input int s);
        return (x << s) | (x >> (8 - s));
    endfunction

    // S-boxes from the multiplicative inverse and affine map
    task automatic build_sboxes();
        logic [7:0] p, q;
        p = 8'h01;
        q = 8'h01;
        do
        begin
            p = p ^ {p[6:0], 1'b0} ^ (p[7] ? 8'h1b : 8'h00);
            q = q ^ {q[6:0], 1'b0};
            q = q ^ {q[5:0], 2'b0};
            q = q ^ {q[3:0], 4'b0};
            if (q[7]) q = q ^ 8'h09;
            fwd_sb[p] = q ^ rol8(q, 1) ^ rol8(q, 2) ^ rol8(q, 3) ^ rol8(q, 4) ^ 8'h63;
        end while (p != 8'h01);
        fwd_sb[0] = 8'h63;
        for (int i = 0; i < 256; i++) inv_sb[fwd_sb[i]] = i[7:0];
    endtask

    function automatic logic [7:0] byte_at(input logic [127:0] s, input int k);
        return s[127 - 8 * k -: 8];
    endfunction

    function automatic logic [127:0] mix_state(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++)
        begin
            a0 = byte_at(s, 4 * c);
            a1 = byte_at(s, 4 * c + 1);
            a2 = byte_at(s, 4 * c + 2);
            a3 = byte_at(s, 4 * c + 3);
            if (!inv)
                r[127 - 32 * c -: 32] = {
                    gf_x2(a0) ^ gf_x2(a1) ^ a1 ^ a2 ^ a3,
                    a0 ^ gf_x2(a1) ^ gf_x2(a2) ^ a2 ^ a3,
                    a0 ^ a1 ^ gf_x2(a2) ^ gf_x2(a3) ^ a3,
                    gf_x2(a0) ^ a0 ^ a1 ^ a2 ^ gf_x2(a3)};
            else
                r[127 - 32 * c -: 32] = {
                    gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13) ^ gf_mul(a3, 8'd9),
                    gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11) ^ gf_mul(a3, 8'd13),
                    gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^ gf_mul(a2, 8'd14) ^ gf_mul(a3, 8'd11),
                    gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9) ^ gf_mul(a3, 8'd14)};
        end
        return r;
    endfunction

    function automatic logic [127:0] subst_rows(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        int moved;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                moved = r + 4 * ((c + r) % 4);
                if (!inv) t[127 - 8 * (r + 4 * c) -: 8] = fwd_sb[byte_at(s, moved)];
                else t[127 - 8 * moved -: 8] = inv_sb[byte_at(s, r + 4 * c)];
            end
        return t;
    endfunction

    function automatic logic [127:0] aes_block(input logic [127:0] blk, input logic inv);
        logic [127:0] s;
        s = blk ^ (inv ? dec_rk[0] : enc_rk[0]);
        for (int r = 1; r <= m_rounds; r++)
        begin
            s = subst_rows(s, inv);
            if (r != m_rounds) s = mix_state(s, inv);
            s = s ^ (inv ? dec_rk[r] : enc_rk[r]);
        end
        return s;
    endfunction

    function automatic logic [31:0] sub_w(input logic [31:0] t);
        return {fwd_sb[t[31:24]], fwd_sb[t[23:16]], fwd_sb[t[15:8]], fwd_sb[t[7:0]]};
    endfunction

    // round keys, then the equivalent inverse cipher keys
    task automatic expand_schedule();
        logic [31:0] w [60];
        logic [31:0] t;
        logic [7:0] rc;
        int nk;
        int total;
        rc = 8'h01;
        nk = (m_ksz == KSZ_128) ? 4 : (m_ksz == KSZ_192) ? 6 : 8;
        m_rounds = nk + 6;
        total = 4 * (m_rounds + 1);
        for (int i = 0; i < nk; i++)
            w[i] = (i % 2) ? m_key[i / 2][31:0] : m_key[i / 2][63:32];
        for (int i = nk; i < total; i++)
        begin
            t = w[i - 1];
            if (i % nk == 0)
            begin
                t = sub_w({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gf_x2(rc);
            end
            else if (nk > 6 && i % nk == 4)
                t = sub_w(t);
            w[i] = w[i - nk] ^ t;
        end
        for (int i = 0; i <= m_rounds; i++)
            enc_rk[i] = {w[4 * i], w[4 * i + 1], w[4 * i + 2], w[4 * i + 3]};
        for (int i = 0; i <= m_rounds; i++)
            dec_rk[i] = (i != 0 && i != m_rounds) ? mix_state(enc_rk[m_rounds - i], 1'b1)
                                                  : enc_rk[m_rounds - i];
        m_keys_ok = 1'b1;
    endtask

    // expected result of one accepted block
    task automatic predict_block(input blk_item_t it);
        logic [127:0] b, r, ks, mask;
        int n;
        b = {it.hi, it.lo};
        n = it.cnt;
        if (it.rst) m_chain = {m_ivh, m_ivl};
        if (!m_keys_ok) expand_schedule();
        case (m_op)
            OP_ECB_ENC: r = aes_block(b, 1'b0);
            OP_ECB_DEC: r = aes_block(b, 1'b1);
            OP_CBC_ENC:
            begin
                r = aes_block(b ^ m_chain, 1'b0);
                m_chain = r;
            end
            OP_CBC_DEC:
            begin
                r = aes_block(b, 1'b1) ^ m_chain;
                m_chain = b;
            end
            OP_CTR:
            begin
                if (n > 16) n = 16;
                if (n == 0) r = '0;
                else
                begin
                    ks = aes_block(m_chain, 1'b0);
                    m_chain = m_chain + 128'd1;
                    mask = (n == 16) ? {128{1'b1}} : ~({128{1'b1}} >> (8 * n));
                    r = (b ^ ks) & mask;
                end
            end
            default: r = '0;
        endcase
        expected_results.push_back(r);
    endtask

    // driver: keeps valid up until the transfer, then offers the next block or idles at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vif.valid      <= 1'b0;
            in_vif.block_high <= '0;
            in_vif.block_low  <= '0;
            in_vif.byte_count <= '0;
            in_vif.restart    <= 1'b0;
        end
        else
        begin
            if (in_vif.valid && in_vif.ready)
            begin
                predict_block({in_vif.block_high, in_vif.block_low,
                               in_vif.byte_count, in_vif.restart});
                blocks_sent++;
            end
            if (!in_vif.valid || in_vif.ready)
            begin
                if (pending_blocks.size() > 0 && (no_idle || $urandom_range(0, 99) >= 20))
                begin
                    blk_item_t nx;
                    nx = pending_blocks.pop_front();
                    in_vif.valid      <= 1'b1;
                    in_vif.block_high <= nx.hi;
                    in_vif.block_low  <= nx.lo;
                    in_vif.byte_count <= nx.cnt;
                    in_vif.restart    <= nx.rst;
                end
                else
                    in_vif.valid <= 1'b0;
            end
        end
    end

    // long receiver hold, counted in cycles
    always @(posedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_cnt <= 400;
        end
        else if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
    end

    // monitor: compare each transfer with the oldest expectation; random and long stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vif.ready <= 1'b0;
        else
        begin
            if (out_vif.valid && out_vif.ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %h_%h", $time,
                             out_vif.result_high, out_vif.result_low);
                    errors++;
                end
                else
                begin
                    logic [127:0] ex;
                    ex = expected_results.pop_front();
                    if (out_vif.result_high !== ex[127:64])
                    begin
                        $display("%0t: result_high expected %h actual %h", $time,
                                 ex[127:64], out_vif.result_high);
                        errors++;
                    end
                    if (out_vif.result_low !== ex[63:0])
                    begin
                        $display("%0t: result_low expected %h actual %h", $time,
                                 ex[63:0], out_vif.result_low);
                        errors++;
                    end
                end
            end
            if ((hold_req && !hold_taken) || hold_cnt > 0)
                out_vif.ready <= 1'b0;
            else
                out_vif.ready <= no_idle || ($urandom_range(0, 99) >= 20);
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx) inside
            REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3:
            begin
                m_key[idx[1:0]] = val;
                m_keys_ok = 1'b0;
            end
            REG_IVH: m_ivh = val;
            REG_IVL: m_ivl = val;
            REG_KSZ:
            begin
                m_ksz = val[1:0];
                m_keys_ok = 1'b0;
            end
            REG_OP:  m_op = val[2:0];
            default: ;
        endcase
    endtask

    task automatic cfg_all(input logic [255:0] key, input logic [127:0] iv,
                           input logic [1:0] ksz, input logic [2:0] op);
        cfg_write(REG_KEY0, key[255:192]);
        cfg_write(REG_KEY1, key[191:128]);
        cfg_write(REG_KEY2, key[127:64]);
        cfg_write(REG_KEY3, key[63:0]);
        cfg_write(REG_IVH, iv[127:64]);
        cfg_write(REG_IVL, iv[63:0]);
        cfg_write(REG_KSZ, {62'd0, ksz});
        cfg_write(REG_OP, {61'd0, op});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_block(input logic [127:0] b, input int cnt, input logic rs);
        pending_blocks.push_back({b, cnt[CNT_W-1:0], rs});
    endtask

    // wait for all queued blocks to drain before touching the registers
    task automatic drain();
        while (pending_blocks.size() > 0 || in_vif.valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [127:0] rnd128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    initial
    begin
        logic [255:0] key;
        logic [2:0] op;
        int nitems;
        m_key[0] = '0; m_key[1] = '0; m_key[2] = '0; m_key[3] = '0;
        m_ivh = '0; m_ivl = '0; m_ksz = KSZ_128; m_op = OP_ECB_ENC;
        m_chain = '0; m_keys_ok = 1'b0; m_rounds = 10;
        build_sboxes();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes of keys and blocks, every mode, CTR byte counts and wrap
        cfg_all('0, '0, KSZ_128, OP_ECB_ENC);
        push_block('0, 16, 1'b0);
        push_block({128{1'b1}}, 16, 1'b1);
        drain();
        cfg_all({256{1'b1}}, '0, KSZ_192, OP_ECB_DEC);
        push_block('0, 0, 1'b0);
        push_block({128{1'b1}}, 31, 1'b0);
        drain();
        cfg_all({rnd128(), rnd128()}, {128{1'b1}}, KSZ_256, OP_CBC_ENC);
        push_block(rnd128(), 16, 1'b1);
        push_block(rnd128(), 5, 1'b0);
        push_block('0, 16, 1'b0);
        drain();
        cfg_all({rnd128(), rnd128()}, rnd128(), KSZ_ALT, OP_CBC_DEC);
        push_block(rnd128(), 16, 1'b1);
        push_block(rnd128(), 16, 1'b0);
        push_block({128{1'b1}}, 16, 1'b0);
        drain();
        // counter wraps from all ones
        cfg_all({rnd128(), rnd128()}, {128{1'b1}}, KSZ_128, OP_CTR);
        push_block(rnd128(), 16, 1'b1);
        push_block(rnd128(), 0, 1'b0);
        push_block(rnd128(), 1, 1'b0);
        push_block(rnd128(), 7, 1'b0);
        push_block(rnd128(), 8, 1'b0);
        push_block(rnd128(), 9, 1'b0);
        push_block(rnd128(), 15, 1'b0);
        push_block(rnd128(), 17, 1'b0);
        push_block(rnd128(), 31, 1'b0);
        drain();
        // IV change alone is seen only at a restart
        cfg_write(REG_IVL, 64'h0123456789abcdef);
        @(posedge clk);
        cfg_we <= 1'b0;
        push_block(rnd128(), 16, 1'b0);
        push_block(rnd128(), 16, 1'b1);
        drain();
        for (int k = OP_RSVD_LO; k <= OP_RSVD_HI; k++)
        begin
            cfg_all({rnd128(), rnd128()}, rnd128(), KSZ_192, k[2:0]);
            push_block(rnd128(), 16, 1'b1);
            drain();
        end
        cfg_all({rnd128(), rnd128()}, rnd128(), KSZ_128, OP_CTR);
        push_block(rnd128(), 16, 1'b0);
        drain();

        // random phases: one setting each, mostly well-formed messages
        for (int ph = 0; ph < 62; ph++)
        begin
            key = {rnd128(), rnd128()};
            if (ph % 13 == 5) key = '0;
            if (ph % 13 == 9) key = {256{1'b1}};
            op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
            cfg_all(key, ($urandom_range(0, 5) == 0) ? {{64{1'b1}}, 64'hffff_ffff_ffff_fff0}
                                                      : rnd128(),
                    2'($urandom_range(0, 3)), op);
            no_idle <= (ph == 20);
            if (ph == 30) hold_req <= 1'b1;
            nitems = $urandom_range(20, 36);
            for (int i = 0; i < nitems; i++)
            begin
                int cnt;
                cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : 16;
                push_block(rnd128(), cnt, (i == 0) || ($urandom_range(0, 9) == 0));
            end
            drain();
        end

        $display("Covered %0d blocks and %0d results over all modes, key sizes 128/192/256,",
                 blocks_sent, results_seen);
        $display("CTR short blocks and counter wrap, reserved modes, and output back-pressure.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Timeout with %0d results still expected", expected_results.size());
        $display("DONE: errors detected");
        $finish;
    end
endmodule
